FILE: rtl/uptq_pkg.sv
// shared types, character codes and phase encoding for the uri tokenizer
package uptq_pkg;

   typedef enum logic [2:0] {
      PH_SLASH = 3'd0,
      PH_PATH  = 3'd1,
      PH_NAME  = 3'd2,
      PH_VALUE = 3'd3,
      PH_HEX1  = 3'd4,
      PH_HEX2  = 3'd5,
      PH_FRAG  = 3'd6,
      PH_DROP  = 3'd7
   } phase_type;

   localparam logic [2:0] TK_NONE  = 3'd0;
   localparam logic [2:0] TK_PATH  = 3'd1;
   localparam logic [2:0] TK_NAME  = 3'd2;
   localparam logic [2:0] TK_VALUE = 3'd3;
   localparam logic [2:0] TK_FRAG  = 3'd4;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] char_out;
      logic       closes_segment;
      logic       closes_name;
      logic       closes_param;
      logic       uri_done;
      logic       bad_uri;
   } rsp_type;

   // outcome of one tokenizer step
   typedef struct packed {
      phase_type  phase;
      logic [3:0] high_nibble;
      logic       has_result;
      rsp_type    rsp;
   } step_type;

endpackage

FILE: rtl/uptq_step.sv
// combinational tokenizer step: next phase, escape nibble and result for one character
module uptq_step (
   input  uptq_pkg::phase_type phase,
   input  logic [3:0]          high_nibble,
   input  uptq_pkg::req_type   item,
   output uptq_pkg::step_type  step
);

   // {is_hex, value}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      begin
         r = 5'd0;
         if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
         end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
         end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
         end
         return r;
      end
   endfunction

   logic [7:0] c;
   logic       e;
   logic [4:0] hv;

   assign c  = item.char_in;
   assign e  = item.end_mark;
   assign hv = hex_val(c);

   always_comb begin
      step             = '0;
      step.phase       = phase;
      step.high_nibble = high_nibble;
      step.rsp.token_kind = uptq_pkg::TK_NONE;
      case (phase)
         uptq_pkg::PH_SLASH: begin
            if (e || c != uptq_pkg::CH_SLASH) begin
               step.has_result   = 1'b1;
               step.rsp.uri_done = 1'b1;
               step.rsp.bad_uri  = 1'b1;
               step.phase        = e ? uptq_pkg::PH_SLASH : uptq_pkg::PH_DROP;
            end else begin
               step.phase = uptq_pkg::PH_PATH;
            end
         end
         uptq_pkg::PH_PATH: begin
            step.has_result = 1'b1;
            if (e) begin
               step.rsp.closes_segment = 1'b1;
               step.rsp.uri_done       = 1'b1;
               step.phase              = uptq_pkg::PH_SLASH;
            end else if (c == uptq_pkg::CH_SLASH) begin
               step.rsp.closes_segment = 1'b1;
            end else if (c == uptq_pkg::CH_QUEST) begin
               step.rsp.closes_segment = 1'b1;
               step.phase              = uptq_pkg::PH_NAME;
            end else begin
               step.rsp.token_kind = uptq_pkg::TK_PATH;
               step.rsp.char_out   = c;
            end
         end
         uptq_pkg::PH_NAME: begin
            step.has_result = 1'b1;
            if (e) begin
               step.rsp.uri_done = 1'b1;
               step.rsp.bad_uri  = 1'b1;
               step.phase        = uptq_pkg::PH_SLASH;
            end else if (c == uptq_pkg::CH_EQUALS) begin
               step.rsp.closes_name = 1'b1;
               step.phase           = uptq_pkg::PH_VALUE;
            end else begin
               step.rsp.token_kind = uptq_pkg::TK_NAME;
               step.rsp.char_out   = c;
            end
         end
         uptq_pkg::PH_VALUE: begin
            step.has_result = 1'b1;
            if (e) begin
               step.rsp.closes_param = 1'b1;
               step.rsp.uri_done     = 1'b1;
               step.phase            = uptq_pkg::PH_SLASH;
            end else if (c == uptq_pkg::CH_AMP) begin
               step.rsp.closes_param = 1'b1;
               step.phase            = uptq_pkg::PH_NAME;
            end else if (c == uptq_pkg::CH_HASH) begin
               step.rsp.closes_param = 1'b1;
               step.phase            = uptq_pkg::PH_FRAG;
            end else if (c == uptq_pkg::CH_PERCENT) begin
               step.has_result = 1'b0;
               step.phase      = uptq_pkg::PH_HEX1;
            end else begin
               step.rsp.token_kind = uptq_pkg::TK_VALUE;
               step.rsp.char_out   = c;
            end
         end
         uptq_pkg::PH_HEX1: begin
            if (e || !hv[4]) begin
               step.has_result   = 1'b1;
               step.rsp.uri_done = 1'b1;
               step.rsp.bad_uri  = 1'b1;
               step.phase        = e ? uptq_pkg::PH_SLASH : uptq_pkg::PH_DROP;
            end else begin
               step.high_nibble = hv[3:0];
               step.phase       = uptq_pkg::PH_HEX2;
            end
         end
         uptq_pkg::PH_HEX2: begin
            step.has_result = 1'b1;
            if (e || !hv[4]) begin
               step.rsp.uri_done = 1'b1;
               step.rsp.bad_uri  = 1'b1;
               step.phase        = e ? uptq_pkg::PH_SLASH : uptq_pkg::PH_DROP;
            end else begin
               step.rsp.token_kind = uptq_pkg::TK_VALUE;
               step.rsp.char_out   = {high_nibble, hv[3:0]};
               step.phase          = uptq_pkg::PH_VALUE;
            end
         end
         uptq_pkg::PH_FRAG: begin
            step.has_result = 1'b1;
            if (e) begin
               step.rsp.uri_done = 1'b1;
               step.phase        = uptq_pkg::PH_SLASH;
            end else begin
               step.rsp.token_kind = uptq_pkg::TK_FRAG;
               step.rsp.char_out   = c;
            end
         end
         default: begin
            // discarding after an error, until the terminator
            if (e) begin
               step.phase = uptq_pkg::PH_SLASH;
            end
         end
      endcase
   end

endmodule

FILE: rtl/uri_path_query_tokenizer.sv
// top level of the uri path/query/fragment tokenizer with percent decoding
// requests pass an input register, then a result register that drives rsp_valid
// throughput: one character per cycle while results are not held back by rsp_ready
// no response for the leading slash, '%', first hex digit or items after an error
// reset: synchronous, clears both valid flags and returns to expecting the leading slash
module uri_path_query_tokenizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uptq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output uptq_pkg::rsp_type rsp_data
);

   // input register
   logic              in_valid_ff, in_valid_in;
   uptq_pkg::req_type in_item_ff,  in_item_in;

   // tokenizer state
   uptq_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          nibble_ff, nibble_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   uptq_pkg::rsp_type out_item_ff,  out_item_in;

   uptq_pkg::step_type step;
   logic               advance;

   uptq_step u_step (
      .phase       (phase_ff),
      .high_nibble (nibble_ff),
      .item        (in_item_ff),
      .step        (step)
   );

   // the held item moves on when its result has room, or when it gives none
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready || !step.has_result);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      phase_in     = phase_ff;
      nibble_in    = nibble_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;

      // response transaction taken by the sink
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         phase_in    = step.phase;
         nibble_in   = step.high_nibble;
         in_valid_in = 1'b0;
         if (step.has_result) begin
            out_valid_in = 1'b1;
            out_item_in  = step.rsp;
         end
      end

      // new request transaction
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= uptq_pkg::PH_SLASH;
         nibble_ff    <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         nibble_ff    <= nibble_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

endmodule

FILE: tb/uptq_tb_pkg.sv
// scoreboard for the uri tokenizer testbench: expected-token predictor and response checks
`timescale 1ns / 1ps

package uptq_tb_pkg;

   // value of a hex digit in either case, -1 for anything else
   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   class token_ledger;
      uptq_pkg::phase_type pos;
      logic [3:0]          hi_digit;
      uptq_pkg::rsp_type   pending_tokens[$];
      int unsigned         mismatches;

      function new();
         pos        = uptq_pkg::PH_SLASH;
         hi_digit   = '0;
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // advance the tokenizer state by one accepted transaction
      function void note_char(uptq_pkg::req_type r);
         uptq_pkg::rsp_type tok;
         logic    emit;
         logic    bad;
         int      h;
         tok  = '0;
         emit = 1'b1;
         bad  = 1'b0;
         h    = r.end_mark ? -1 : hex_value(r.char_in);
         case (pos)
            uptq_pkg::PH_SLASH: begin
               if (r.end_mark || r.char_in != uptq_pkg::CH_SLASH) begin
                  bad = 1'b1;
               end else begin
                  pos  = uptq_pkg::PH_PATH;
                  emit = 1'b0;
               end
            end
            uptq_pkg::PH_PATH: begin
               if (r.end_mark) begin
                  tok.closes_segment = 1'b1;
                  tok.uri_done       = 1'b1;
                  pos                = uptq_pkg::PH_SLASH;
               end else if (r.char_in == uptq_pkg::CH_SLASH) begin
                  tok.closes_segment = 1'b1;
               end else if (r.char_in == uptq_pkg::CH_QUEST) begin
                  tok.closes_segment = 1'b1;
                  pos                = uptq_pkg::PH_NAME;
               end else begin
                  tok.token_kind = uptq_pkg::TK_PATH;
                  tok.char_out   = r.char_in;
               end
            end
            uptq_pkg::PH_NAME: begin
               if (r.end_mark) begin
                  bad = 1'b1;
               end else if (r.char_in == uptq_pkg::CH_EQUALS) begin
                  tok.closes_name = 1'b1;
                  pos             = uptq_pkg::PH_VALUE;
               end else begin
                  tok.token_kind = uptq_pkg::TK_NAME;
                  tok.char_out   = r.char_in;
               end
            end
            uptq_pkg::PH_VALUE: begin
               if (r.end_mark) begin
                  tok.closes_param = 1'b1;
                  tok.uri_done     = 1'b1;
                  pos              = uptq_pkg::PH_SLASH;
               end else if (r.char_in == uptq_pkg::CH_AMP) begin
                  tok.closes_param = 1'b1;
                  pos              = uptq_pkg::PH_NAME;
               end else if (r.char_in == uptq_pkg::CH_HASH) begin
                  tok.closes_param = 1'b1;
                  pos              = uptq_pkg::PH_FRAG;
               end else if (r.char_in == uptq_pkg::CH_PERCENT) begin
                  pos  = uptq_pkg::PH_HEX1;
                  emit = 1'b0;
               end else begin
                  tok.token_kind = uptq_pkg::TK_VALUE;
                  tok.char_out   = r.char_in;
               end
            end
            uptq_pkg::PH_HEX1: begin
               if (h < 0) begin
                  bad = 1'b1;
               end else begin
                  hi_digit = h[3:0];
                  pos      = uptq_pkg::PH_HEX2;
                  emit     = 1'b0;
               end
            end
            uptq_pkg::PH_HEX2: begin
               if (h < 0) begin
                  bad = 1'b1;
               end else begin
                  tok.token_kind = uptq_pkg::TK_VALUE;
                  tok.char_out   = {hi_digit, h[3:0]};
                  pos            = uptq_pkg::PH_VALUE;
               end
            end
            uptq_pkg::PH_FRAG: begin
               if (r.end_mark) begin
                  tok.uri_done = 1'b1;
                  pos          = uptq_pkg::PH_SLASH;
               end else begin
                  tok.token_kind = uptq_pkg::TK_FRAG;
                  tok.char_out   = r.char_in;
               end
            end
            default: begin
               emit = 1'b0;
               if (r.end_mark) pos = uptq_pkg::PH_SLASH;
            end
         endcase
         if (bad) begin
            tok          = '0;
            tok.uri_done = 1'b1;
            tok.bad_uri  = 1'b1;
            pos          = r.end_mark ? uptq_pkg::PH_SLASH : uptq_pkg::PH_DROP;
         end
         if (emit) pending_tokens = {pending_tokens, tok};
      endfunction

      task compare(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
      endtask

      task check_token(uptq_pkg::rsp_type got);
         uptq_pkg::rsp_type want;
         if (pending_tokens.size() == 0) begin
            report($sformatf("response %h with nothing expected", got));
            return;
         end
         want = pending_tokens.pop_front();
         compare("token_kind", 8'(got.token_kind), 8'(want.token_kind));
         compare("char_out", got.char_out, want.char_out);
         compare("closes_segment", 8'(got.closes_segment), 8'(want.closes_segment));
         compare("closes_name", 8'(got.closes_name), 8'(want.closes_name));
         compare("closes_param", 8'(got.closes_param), 8'(want.closes_param));
         compare("uri_done", 8'(got.uri_done), 8'(want.uri_done));
         compare("bad_uri", 8'(got.bad_uri), 8'(want.bad_uri));
      endtask
   endclass

endpackage

FILE: tb/tb.sv
// top-level testbench for the uri path/query/fragment tokenizer
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_TAIL   = 300;      // last items run with no idling on either side
   localparam int DRAIN_CYCLES = 16;       // pipeline is two deep, so this is ample
   localparam int CYCLE_LIMIT  = 500000;

   // ways a random uri can be spoilt
   localparam int FLAW_NONE  = 0;
   localparam int FLAW_SLASH = 1;          // leading slash missing
   localparam int FLAW_NAME  = 2;          // terminator while a name is read
   localparam int FLAW_HEX   = 3;          // non-hex character in an escape
   localparam int FLAW_CUT   = 4;          // terminator in the middle of an escape

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   uptq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   uptq_pkg::rsp_type rsp_data;

   bit                       idle_on = 1'b0;
   int unsigned              cycles  = 0;
   uptq_tb_pkg::token_ledger ledger  = new();

   uri_path_query_tokenizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[uri_path_query_tokenizer] ERROR");
         $finish;
      end
   end

   // every response transaction is checked against the oldest expected token
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_token(rsp_data);
   end

   // receiver side: random stall bursts while idling is enabled
   initial begin : rsp_side
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic uptq_pkg::req_type ch(logic [7:0] c);
      return {c, 1'b0};
   endfunction

   // terminator; its character is ignored by the block, so make it random
   function automatic uptq_pkg::req_type term();
      return {8'($urandom), 1'b1};
   endfunction

   // a hex digit in random letter case
   function automatic logic [7:0] hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return ($urandom_range(0, 1) == 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   // one uri: mostly well formed with random content, some spoilt, a little pure noise
   function automatic void make_uri(ref uptq_pkg::req_type q[$]);
      int                kind;
      int                flaw;
      int                nseg;
      int                npar;
      logic [7:0]        b;
      uptq_pkg::req_type r;
      q.delete();
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
         repeat ($urandom_range(1, 10)) begin
            r = {8'($urandom), 1'($urandom_range(0, 7) == 0)};
            q = {q, r};
         end
         q = {q, term()};
         return;
      end
      flaw = (kind < 14) ? FLAW_NONE : $urandom_range(FLAW_SLASH, FLAW_CUT);

      // path: any byte but '?' belongs to it, '/' splits segments
      if (flaw == FLAW_SLASH) begin
         do b = 8'($urandom); while (b == uptq_pkg::CH_SLASH);
         q = {q, ch(b)};
      end else begin
         q = {q, ch(uptq_pkg::CH_SLASH)};
      end
      nseg = $urandom_range(0, 3);
      for (int s = 0; s < nseg; s++) begin
         if (s != 0) q = {q, ch(uptq_pkg::CH_SLASH)};
         repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom); while (b == uptq_pkg::CH_QUEST);
            q = {q, ch(b)};
         end
      end

      // query, with the flaws that need it placed in the last parameter
      if (flaw > FLAW_SLASH || $urandom_range(0, 2) != 0) begin
         q = {q, ch(uptq_pkg::CH_QUEST)};
         npar = $urandom_range(1, 3);
         for (int p = 1; p <= npar; p++) begin
            if (p != 1) q = {q, ch(uptq_pkg::CH_AMP)};
            repeat ($urandom_range(0, 4)) begin
               do b = 8'($urandom); while (b == uptq_pkg::CH_EQUALS);
               q = {q, ch(b)};
            end
            if (p == npar && flaw == FLAW_NAME) begin
               q = {q, term()};
               return;
            end
            q = {q, ch(uptq_pkg::CH_EQUALS)};
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 2) == 0) begin
                  q = {q, ch(uptq_pkg::CH_PERCENT)};
                  q = {q, ch(hex_digit())};
                  q = {q, ch(hex_digit())};
               end else begin
                  do b = 8'($urandom);
                  while (b == uptq_pkg::CH_AMP || b == uptq_pkg::CH_HASH ||
                         b == uptq_pkg::CH_PERCENT);
                  q = {q, ch(b)};
               end
            end
            if (p == npar && flaw >= FLAW_HEX) begin
               q = {q, ch(uptq_pkg::CH_PERCENT)};
               if ($urandom_range(0, 1) == 1) q = {q, ch(hex_digit())};
               if (flaw == FLAW_HEX) begin
                  do b = 8'($urandom); while (uptq_tb_pkg::hex_value(b) >= 0);
                  q = {q, ch(b)};
                  // trailing junk that must be discarded
                  repeat ($urandom_range(0, 3)) q = {q, ch(8'($urandom))};
               end
               q = {q, term()};
               return;
            end
         end
         // fragment is only reachable from a value
         if ($urandom_range(0, 2) == 0) begin
            q = {q, ch(uptq_pkg::CH_HASH)};
            repeat ($urandom_range(0, 5)) q = {q, ch(8'($urandom))};
         end
      end
      q = {q, term()};
   endfunction

   // present one request transaction, holding it until accepted
   task automatic send_item(input uptq_pkg::req_type r);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_char(r);
   endtask

   initial begin : stimulus
      uptq_pkg::req_type uri[$];
      int                sent;
      sent = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: bare terminator, missing slash then discard, zero and 0xff
      // characters, second '?' and '&'/'#' inside a name, '=' inside a value,
      // escapes in both letter cases, fragment, then a bad hex digit
      idle_on = 1'b1;
      uri = '{term(),
              ch("x"), term(),
              ch(uptq_pkg::CH_SLASH), ch(8'h00), ch(uptq_pkg::CH_SLASH),
              ch(uptq_pkg::CH_QUEST), ch(uptq_pkg::CH_QUEST),
              ch(uptq_pkg::CH_AMP), ch(uptq_pkg::CH_HASH),
              ch(uptq_pkg::CH_EQUALS), ch(uptq_pkg::CH_EQUALS),
              ch(uptq_pkg::CH_PERCENT), ch("A"), ch("f"),
              ch(uptq_pkg::CH_AMP), ch("x"), ch(uptq_pkg::CH_EQUALS),
              ch(uptq_pkg::CH_HASH), ch(8'hFF), term(),
              ch(uptq_pkg::CH_SLASH), ch(uptq_pkg::CH_QUEST),
              ch(uptq_pkg::CH_EQUALS), ch(uptq_pkg::CH_PERCENT), ch("G"),
              term()};
      foreach (uri[i]) send_item(uri[i]);

      // random uris; idling switched per uri so there are quiet stretches too
      while (sent < RANDOM_ITEMS) begin
         make_uri(uri);
         idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         foreach (uri[i]) send_item(uri[i]);
         sent += uri.size();
      end
      req_valid <= 1'b0;

      // drain, then leave room for any stray response
      while (ledger.pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("[uri_path_query_tokenizer] OK");
      end else begin
         $display("[uri_path_query_tokenizer] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/uptq_pkg.sv
rtl/uptq_step.sv
rtl/uri_path_query_tokenizer.sv
tb/uptq_tb_pkg.sv
tb/tb.sv
